/* rtl/ps2dft_pkg.sv */
// Package for the PS/2 device frame transmitter.
// Holds the wait counter width, register indexes, the result record type and
// the wait saturation helper. No dependencies.
package ps2dft_pkg;

    // Width of the tick wait counter.
    localparam int WAIT_BITS = 18;
    localparam int WAIT_MAX  = (1 << WAIT_BITS) - 1;

    // Width of an unsaturated wait request (three times a 16-bit value).
    localparam int REQ_BITS = 18;

    // Configuration register indexes.
    localparam logic CFG_SETUP_TICKS     = 1'b0;
    localparam logic CFG_CLOCK_LOW_TICKS = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [15:0] SETUP_TICKS_RESET     = 16'd240;
    localparam logic [15:0] CLOCK_LOW_TICKS_RESET = 16'd480;

    typedef logic [WAIT_BITS-1:0] wait_t;

    // One result item.
    typedef struct packed {
        logic rejected;
        logic sending;
        logic pull_data_low;
        logic pull_clock_low;
    } result_t;

    // A wait of zero ticks counts as one; long waits clip to the counter range.
    function automatic wait_t sat_wait(input logic [REQ_BITS-1:0] n);
        wait_t result;
        if (n == '0)
        begin
            result = wait_t'(1);
        end
        else if (32'(n) > 32'(WAIT_MAX))
        begin
            result = wait_t'(WAIT_MAX);
        end
        else
        begin
            result = wait_t'(n);
        end
        return result;
    endfunction

endpackage

/* rtl/ps2dft_core.sv */
// Frame sequencer of the PS/2 device frame transmitter.
// Holds the frame state and the configuration registers and computes the
// result of each accepted transaction. Depends on ps2dft_pkg.
module ps2dft_core
    import ps2dft_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  logic          func,
    input  logic [7:0]    send_byte,
    input  logic          clock_line_level,
    input  logic          data_line_level,
    input  logic          cfg_fire,
    input  logic          cfg_index,
    input  logic [15:0]   cfg_data,
    output result_t       result
);

    typedef enum logic [1:0] {
        PH_SETUP_PRE  = 2'd0,
        PH_CLOCK_LOW  = 2'd1,
        PH_SETUP_POST = 2'd2,
        PH_GAP        = 2'd3
    } phase_t;

    localparam logic [3:0] SLOT_START     = 4'd0;
    localparam logic [3:0] SLOT_LAST_DATA = 4'd8;
    localparam logic [3:0] SLOT_PARITY    = 4'd9;
    localparam logic [3:0] SLOT_STOP      = 4'd10;
    localparam logic [3:0] SLOT_GAP       = 4'd11;

    logic [15:0] setup_ticks_reg;
    logic [15:0] clock_low_ticks_reg;

    logic        active_reg, active_next;
    logic [3:0]  slot_reg, slot_next;
    phase_t      phase_reg, phase_next;
    wait_t       wait_reg, wait_next;
    logic [7:0]  shift_reg, shift_next;
    logic        parity_reg, parity_next;
    logic        clock_low_reg, clock_low_next;
    logic        data_low_reg, data_low_next;
    logic        rejected;

    wait_t             setup_wait;
    wait_t             low_wait;
    wait_t             gap_wait;
    logic [REQ_BITS-1:0] gap_req;
    logic [3:0]        slot_inc;

    // Wait lengths derived from the configuration.
    assign gap_req    = {2'b00, clock_low_ticks_reg} + {1'b0, clock_low_ticks_reg, 1'b0};
    assign setup_wait = sat_wait({2'b00, setup_ticks_reg});
    assign low_wait   = sat_wait({2'b00, clock_low_ticks_reg});
    assign gap_wait   = sat_wait(gap_req);
    assign slot_inc   = slot_reg + 4'd1;

    // Next frame state for the accepted transaction.
    always_comb
    begin
        active_next    = active_reg;
        slot_next      = slot_reg;
        phase_next     = phase_reg;
        wait_next      = wait_reg;
        shift_next     = shift_reg;
        parity_next    = parity_reg;
        clock_low_next = clock_low_reg;
        data_low_next  = data_low_reg;
        rejected       = 1'b0;

        if (in_fire)
        begin
            if (func)
            begin
                if (active_reg || !clock_line_level || !data_line_level)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    // Start bit: data low, then setup before the first clock.
                    active_next    = 1'b1;
                    shift_next     = send_byte;
                    parity_next    = 1'b1;
                    clock_low_next = 1'b0;
                    slot_next      = SLOT_START;
                    phase_next     = PH_SETUP_PRE;
                    data_low_next  = 1'b1;
                    wait_next      = setup_wait;
                end
            end
            else if (active_reg)
            begin
                if (wait_reg > wait_t'(1))
                begin
                    wait_next = wait_reg - wait_t'(1);
                end
                else
                begin
                    case (phase_reg)
                        PH_SETUP_PRE:
                        begin
                            clock_low_next = 1'b1;
                            phase_next     = PH_CLOCK_LOW;
                            wait_next      = low_wait;
                        end
                        PH_CLOCK_LOW:
                        begin
                            clock_low_next = 1'b0;
                            phase_next     = PH_SETUP_POST;
                            wait_next      = setup_wait;
                        end
                        PH_SETUP_POST:
                        begin
                            if (slot_reg < SLOT_STOP)
                            begin
                                // Move on to the next bit and set the data line.
                                slot_next  = slot_inc;
                                phase_next = PH_SETUP_PRE;
                                wait_next  = setup_wait;
                                if (slot_inc <= SLOT_LAST_DATA)
                                begin
                                    data_low_next = !shift_reg[0];
                                    parity_next   = parity_reg ^ shift_reg[0];
                                    shift_next    = {1'b0, shift_reg[7:1]};
                                end
                                else if (slot_inc == SLOT_PARITY)
                                begin
                                    data_low_next = !parity_reg;
                                end
                                else
                                begin
                                    data_low_next = 1'b0;
                                end
                            end
                            else
                            begin
                                slot_next  = SLOT_GAP;
                                phase_next = PH_GAP;
                                wait_next  = gap_wait;
                            end
                        end
                        default:
                        begin
                            // End of the trailing gap: back to idle.
                            active_next    = 1'b0;
                            slot_next      = SLOT_START;
                            phase_next     = PH_SETUP_PRE;
                            wait_next      = '0;
                            clock_low_next = 1'b0;
                            data_low_next  = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    // Result of the transaction, taken from the updated state.
    always_comb
    begin
        result.pull_clock_low = clock_low_next;
        result.pull_data_low  = data_low_next;
        result.sending        = active_next;
        result.rejected       = rejected;
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            slot_reg      <= SLOT_START;
            phase_reg     <= PH_SETUP_PRE;
            wait_reg      <= '0;
            shift_reg     <= '0;
            parity_reg    <= 1'b1;
            clock_low_reg <= 1'b0;
            data_low_reg  <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            slot_reg      <= slot_next;
            phase_reg     <= phase_next;
            wait_reg      <= wait_next;
            shift_reg     <= shift_next;
            parity_reg    <= parity_next;
            clock_low_reg <= clock_low_next;
            data_low_reg  <= data_low_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_ticks_reg     <= SETUP_TICKS_RESET;
            clock_low_ticks_reg <= CLOCK_LOW_TICKS_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_SETUP_TICKS:     setup_ticks_reg     <= cfg_data;
                CFG_CLOCK_LOW_TICKS: clock_low_ticks_reg <= cfg_data;
                default:             setup_ticks_reg     <= setup_ticks_reg;
            endcase
        end
    end

`ifndef SYNTHESIS
    // An idle block has no wait pending; a busy one always has one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg == (wait_reg != '0)))
        else $error("wait counter does not match the busy flag");

    // The gap phase belongs to the gap slot only.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_GAP) == (slot_reg == SLOT_GAP)))
        else $error("gap phase and gap slot disagree");

    // The slot never runs past the gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        (slot_reg <= SLOT_GAP))
        else $error("bit slot out of range");

    // A refused request leaves the frame untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && rejected) |=> ($stable(active_reg) && $stable(slot_reg)
                                   && $stable(wait_reg) && $stable(data_low_reg)))
        else $error("rejected request changed the frame state");
`endif

endmodule

/* rtl/ps2dft_out_reg.sv */
// Result register of the PS/2 device frame transmitter.
// Holds one result item for the output stream and frees as it is taken.
// Depends on ps2dft_pkg.
module ps2dft_out_reg
    import ps2dft_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    can_load,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    valid_reg;
    result_t data_reg;

    // A new result can enter when the register is empty or drains now.
    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

/* rtl/ps2_device_frame_transmitter.sv */
// PS/2 device-to-host frame transmitter. Each input transaction is either a
// time tick (tuser = 0) or a request to send a byte (tuser = 1), and each one
// yields exactly one result transaction with the open-drain line controls, the
// busy flag and the reject flag. One transaction is taken per clock cycle; the
// result appears in the next cycle from a single result register, which is the
// only thing that throttles the input when the output side stalls. Requests
// are refused while a frame or its trailing gap is in progress or while a
// sensed line is low. Bit timing is counted in ticks set by the two configuration
// registers, which the user must write through the cfg channel only while idle;
// the block does not enforce this. Depends on ps2dft_pkg, ps2dft_core and ps2dft_out_reg.
module ps2_device_frame_transmitter
    import ps2dft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] send_byte, [8] clock_line_level,
                                       // [9] data_line_level, [15:10] zero
    input  logic        s_axis_tuser,  // [0] func
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [0] pull_clock_low, [1] pull_data_low,
                                       // [2] sending, [3] rejected, [7:4] zero
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic    in_fire;
    logic    can_load;
    result_t core_result;
    result_t out_result;

    assign s_axis_tready = can_load;
    assign in_fire       = s_axis_tvalid && can_load;
    assign cfg_ready     = 1'b1;

    ps2dft_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_fire          (in_fire),
        .func             (s_axis_tuser),
        .send_byte        (s_axis_tdata[7:0]),
        .clock_line_level (s_axis_tdata[8]),
        .data_line_level  (s_axis_tdata[9]),
        .cfg_fire         (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .result           (core_result)
    );

    ps2dft_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .load_data (core_result),
        .can_load  (can_load),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    // Pack the result fields, lowest bit first.
    assign m_axis_tdata = {4'b0000, out_result.rejected, out_result.sending,
                           out_result.pull_data_low, out_result.pull_clock_low};

endmodule
